// ----- rtl/sorted_table_search_insert_defines.svh -----
// Assertion macros for the sorted table search/insert checker.
`ifndef SORTED_TABLE_SEARCH_INSERT_DEFINES_SVH
`define SORTED_TABLE_SEARCH_INSERT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, quiet during reset.
`define STS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted table check failed");

// Next-cycle implication, sampled on the rising clock, quiet during reset.
`define STS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted table check failed");

`endif

// ----- rtl/sts_pkg.sv -----
// Shared constants and helpers for the sorted table search/insert block.
`default_nettype none

package sts_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 128;
  localparam int KEY_W       = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int OUT_W       = 8;

  // Result fields carry only the low eight bits of a count or index.
  function automatic logic [OUT_W-1:0] to_out(input logic [CNT_W-1:0] v);
    logic [CNT_W+OUT_W-1:0] w;
    w = {{OUT_W{1'b0}}, v};
    return w[OUT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/sts_ram.sv -----
// Simple dual-port RAM: one write port, one read port with registered data.
`default_nettype none

module sts_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/sorted_table_search_insert.sv -----
// Sorted table of signed keys: binary search, then sorted insert by shifting entries up.
//
// Each accepted key is looked up by binary search over the valid entries of a
// single-port-read, single-port-write table memory, each probe a read and then
// a compare, at most ceil(log2(count+1)) probes. An absent key is dropped and
// reported as table full when the table is full; otherwise it is inserted at
// its lower bound: every later entry moves up one slot at one entry per cycle
// through the memory, then the key is written. in_ready is high only while
// the sequencer is idle; a finished result waits in the output register while
// the next key is taken. No clearing pass is needed after reset.
`default_nettype none

module sorted_table_search_insert (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output      logic                      in_ready,
  input  wire logic [sts_pkg::KEY_W-1:0] in_key,
  output      logic                      out_valid,
  input  wire logic                      out_ready,
  output      logic                      out_found,
  output      logic [sts_pkg::OUT_W-1:0] out_position,
  output      logic                      out_table_full,
  output      logic [sts_pkg::OUT_W-1:0] out_count_now
);
  import sts_pkg::*;

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PROBE = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_INS   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [CNT_W-1:0] lo_r, lo_nxt;
  logic [CNT_W-1:0] hi_r, hi_nxt;
  logic [IDX_W-1:0] mid_r, mid_nxt;
  logic [IDX_W-1:0] dst_r, dst_nxt;
  logic             res_found_r, res_found_nxt;
  logic             res_full_r, res_full_nxt;
  logic [CNT_W-1:0] res_pos_r, res_pos_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             out_found_r, out_found_nxt;
  logic             out_full_r, out_full_nxt;
  logic [OUT_W-1:0] out_pos_r, out_pos_nxt;
  logic [OUT_W-1:0] out_cnt_r, out_cnt_nxt;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [KEY_W-1:0] ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [KEY_W-1:0] ram_rdata;

  logic [CNT_W-1:0] mid_calc;
  logic             in_beat;
  logic             out_beat;
  logic             is_full;

  sts_ram #(
    .DEPTH(TABLE_DEPTH),
    .WIDTH(KEY_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_ready = (state_r == S_IDLE);
  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid_r && out_ready;
  assign is_full  = (count_r == CNT_W'(TABLE_DEPTH));
  assign mid_calc = lo_r + ((hi_r - lo_r) >> 1);

  // Sequencer: search probes, then the shift and insert through the memory.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    key_nxt       = key_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    dst_nxt       = dst_r;
    res_found_nxt = res_found_r;
    res_full_nxt  = res_full_r;
    res_pos_nxt   = res_pos_r;
    ram_we        = 1'b0;
    ram_waddr     = dst_r;
    ram_wdata     = ram_rdata;
    ram_raddr     = mid_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          key_nxt       = in_key;
          lo_nxt        = '0;
          hi_nxt        = count_r;
          res_found_nxt = 1'b0;
          res_full_nxt  = 1'b0;
          res_pos_nxt   = '0;
          state_nxt     = S_PROBE;
        end
      end
      S_PROBE: begin
        if (lo_r < hi_r) begin
          // Issue the read of the middle entry.
          mid_nxt   = mid_calc[IDX_W-1:0];
          ram_raddr = mid_calc[IDX_W-1:0];
          state_nxt = S_CMP;
        end else if (is_full) begin
          // Absent key and no room: drop it.
          res_full_nxt = 1'b1;
          state_nxt    = S_DONE;
        end else if (count_r > lo_r) begin
          // Start the shift with the last valid entry.
          ram_raddr = IDX_W'(count_r - 1'b1);
          dst_nxt   = IDX_W'(count_r);
          state_nxt = S_SHIFT;
        end else begin
          state_nxt = S_INS;
        end
      end
      S_CMP: begin
        if ($signed(key_r) > $signed(ram_rdata)) begin
          lo_nxt    = CNT_W'(mid_r) + 1'b1;
          state_nxt = S_PROBE;
        end else if ($signed(key_r) < $signed(ram_rdata)) begin
          hi_nxt    = CNT_W'(mid_r);
          state_nxt = S_PROBE;
        end else begin
          res_found_nxt = 1'b1;
          res_pos_nxt   = CNT_W'(mid_r);
          state_nxt     = S_DONE;
        end
      end
      S_SHIFT: begin
        // Write the entry just read one slot up, and read the next one down.
        ram_we    = 1'b1;
        ram_waddr = dst_r;
        ram_wdata = ram_rdata;
        if (CNT_W'(dst_r) - 1'b1 > lo_r) begin
          ram_raddr = dst_r - IDX_W'(2);
          dst_nxt   = dst_r - 1'b1;
        end else begin
          state_nxt = S_INS;
        end
      end
      S_INS: begin
        ram_we      = 1'b1;
        ram_waddr   = IDX_W'(lo_r);
        ram_wdata   = key_r;
        count_nxt   = count_r + 1'b1;
        res_pos_nxt = lo_r;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register: loaded when the result leaves the sequencer.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_found_nxt = out_found_r;
    out_full_nxt  = out_full_r;
    out_pos_nxt   = out_pos_r;
    out_cnt_nxt   = out_cnt_r;
    if (out_beat) begin
      out_valid_nxt = 1'b0;
    end
    if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
      out_valid_nxt = 1'b1;
      out_found_nxt = res_found_r;
      out_full_nxt  = res_full_r;
      out_pos_nxt   = to_out(res_pos_r);
      out_cnt_nxt   = to_out(count_r);
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    key_r       <= key_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    mid_r       <= mid_nxt;
    dst_r       <= dst_nxt;
    res_found_r <= res_found_nxt;
    res_full_r  <= res_full_nxt;
    res_pos_r   <= res_pos_nxt;
    out_found_r <= out_found_nxt;
    out_full_r  <= out_full_nxt;
    out_pos_r   <= out_pos_nxt;
    out_cnt_r   <= out_cnt_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_position   = out_pos_r;
  assign out_table_full = out_full_r;
  assign out_count_now  = out_cnt_r;

endmodule

`default_nettype wire

// ----- rtl/sts_checker.sv -----
// Port-level checks for the sorted table search/insert block, bound to the top level.
`default_nettype none

`include "sorted_table_search_insert_defines.svh"

module sts_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_valid,
  input wire logic                      in_ready,
  input wire logic [sts_pkg::KEY_W-1:0] in_key,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic                      out_found,
  input wire logic [sts_pkg::OUT_W-1:0] out_position,
  input wire logic                      out_table_full,
  input wire logic [sts_pkg::OUT_W-1:0] out_count_now
);
  import sts_pkg::*;

  logic [OUT_W-1:0] depth_out;
  logic             key_seen;

  assign depth_out = to_out(CNT_W'(TABLE_DEPTH));
  assign key_seen  = ^in_key || !(^in_key);

  // A dropped key is never also reported as found.
  `STS_ASSERT_IMP(a_full_not_found, out_valid && out_table_full, !out_found)

  // A key is dropped only at a full table, and then reports position zero.
  `STS_ASSERT_IMP(a_full_shape, out_valid && out_table_full && key_seen,
    out_count_now == depth_out && out_position == '0)

  // The block works on one key at a time.
  `STS_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // A stalled result holds.
  `STS_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_found) && $stable(out_position) &&
    $stable(out_table_full) && $stable(out_count_now))

endmodule

bind sorted_table_search_insert sts_checker u_sts_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .in_key        (in_key),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_found     (out_found),
  .out_position  (out_position),
  .out_table_full(out_table_full),
  .out_count_now (out_count_now)
);

`default_nettype wire

// ----- sim/sorted_table_search_insert_tb.sv -----
// Self-checking testbench for the sorted table search/insert block.
`timescale 1ns / 1ps

module sorted_table_search_insert_tb;

  localparam int DEPTH       = sts_pkg::TABLE_DEPTH;
  localparam int KW          = sts_pkg::KEY_W;
  localparam int OW          = sts_pkg::OUT_W;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int MAX_GAP     = 30;
  localparam int DRAIN_WAIT  = 200;
  localparam int PHASE_KEYS  = 113;

  typedef logic signed [KW-1:0] key_t;

  typedef struct packed {
    logic          found;
    logic [OW-1:0] position;
    logic          table_full;
    logic [OW-1:0] count_now;
  } lookup_result_t;

  // Mirror of the key table; predicts each lookup and holds the results still owed.
  class key_table_scoreboard;
    key_t           entries [DEPTH];
    int unsigned    count;
    lookup_result_t owed_q [$];
    int unsigned    errors;

    function new();
      count  = 0;
      errors = 0;
    endfunction

    // Binary search over the valid entries, then sorted insert when there is room.
    function void note_key(key_t key);
      int unsigned    lo;
      int unsigned    hi;
      int unsigned    mid;
      lookup_result_t r;
      lo = 0;
      hi = count;
      r  = '0;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (key > entries[mid]) begin
          lo = mid + 1;
        end else if (key < entries[mid]) begin
          hi = mid;
        end else begin
          r.found    = 1'b1;
          r.position = OW'(mid);
          break;
        end
      end
      if (!r.found) begin
        if (count >= DEPTH) begin
          r.table_full = 1'b1;
          r.position   = '0;
        end else begin
          for (int i = count; i > int'(lo); i--) begin
            entries[i] = entries[i-1];
          end
          entries[lo] = key;
          count++;
          r.position = OW'(lo);
        end
      end
      r.count_now = OW'(count);
      owed_q.push_back(r);
    endfunction

    function void report(string what, lookup_result_t want, lookup_result_t got);
      errors++;
      if (errors <= 10) begin
        $write("%0t: %s: expected found=%0b pos=%0d full=%0b count=%0d, ",
               $time, what, want.found, want.position, want.table_full, want.count_now);
        $display("got found=%0b pos=%0d full=%0b count=%0d",
                 got.found, got.position, got.table_full, got.count_now);
      end
    endfunction

    // Compares one result beat with the oldest prediction.
    function void check_result(lookup_result_t got);
      lookup_result_t want;
      if (owed_q.size() == 0) begin
        report("result beat with nothing owed", '0, got);
        return;
      end
      want = owed_q.pop_front();
      if (got.found !== want.found || got.position !== want.position ||
          got.table_full !== want.table_full || got.count_now !== want.count_now) begin
        report("result mismatch", want, got);
      end
    endfunction
  endclass

  logic          clk       = 1'b0;
  logic          rst_n     = 1'b0;
  logic          in_valid  = 1'b0;
  logic          in_ready;
  key_t          in_key    = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic          out_found;
  logic [OW-1:0] out_position;
  logic          out_table_full;
  logic [OW-1:0] out_count_now;

  int          idle_pct  = 0;
  int          stall_pct = 0;
  int unsigned cycles    = 0;

  key_table_scoreboard sb = new();

  // Hand-picked keys: both extremes, zero and minus one, neighbors, repeats.
  key_t directed_keys [18] = '{
    32'sd5, 32'sd5, 32'h8000_0000, 32'h7FFF_FFFF, 32'sd0, 32'hFFFF_FFFF,
    32'sd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'sd6,
    32'sd4, 32'sd5, 32'h8000_0001, 32'h7FFF_FFFE, 32'sd0, 32'hAAAA_AAAA
  };

  sorted_table_search_insert u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_key         (in_key),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_found      (out_found),
    .out_position   (out_position),
    .out_table_full (out_table_full),
    .out_count_now  (out_count_now)
  );

  // Clock: 8 ns period.
  always begin
    #4;
    clk = 1'b1;
    #4;
    clk = 1'b0;
  end

  // Receiver back-pressure, redrawn every cycle.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Result monitor: every accepted beat is checked against the mirror.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result({out_found, out_position, out_table_full, out_count_now});
    end
  end

  // Run-away guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("sorted_table_search_insert_tb: done, errors");
      $finish;
    end
  end

  // Mostly keys already in the table or close to them, so the table fills slowly
  // and both the found and the full paths see plenty of traffic.
  function automatic key_t pick_key();
    int   sel;
    key_t k;
    sel = $urandom_range(99);
    if (sb.count != 0 && sel < 45) begin
      k = sb.entries[$urandom_range(sb.count - 1)];
    end else if (sb.count != 0 && sel < 60) begin
      k = sb.entries[$urandom_range(sb.count - 1)];
      if ($urandom_range(1)) k = k + 1;
      else k = k - 1;
    end else if (sel < 65) begin
      case ($urandom_range(3))
        0:       k = 32'h8000_0000;
        1:       k = 32'h7FFF_FFFF;
        2:       k = 32'sd0;
        default: k = 32'hFFFF_FFFF;
      endcase
    end else if (sel < 75) begin
      k = key_t'($urandom_range(64)) - 32;
    end else begin
      k = $urandom;
    end
    return k;
  endfunction

  // Presents one key beat, with a random idle gap ahead of it, and waits for acceptance.
  task automatic send_key(input key_t k);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_key   <= k;
    do @(posedge clk); while (!in_ready);
    sb.note_key(k);
  endtask

  // Stimulus: reset, directed keys, then random phases with varied idling.
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_keys[i]) send_key(directed_keys[i]);

    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 67; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 67; end
        default: begin idle_pct = 34; stall_pct = 34; end
      endcase
      repeat (PHASE_KEYS) send_key(pick_key());
    end
    in_valid <= 1'b0;

    // Drain the outstanding results, then give the block time to show anything extra.
    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (sb.errors == 0 && sb.owed_q.size() == 0) begin
      $display("sorted_table_search_insert_tb: done, clean");
    end else begin
      $display("sorted_table_search_insert_tb: done, errors");
    end
    $finish;
  end

endmodule
